// ----- rtl/snrh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrh_pkg
// Shared types, constants and arithmetic helpers for the segment n-gram
// rolling hash block.
// ----------------------------------------------------------------------------
package snrh_pkg;

    localparam int COORD_W  = 6;
    localparam int PROD_W   = 12;
    localparam int SEG_W    = 23;
    localparam int HASH_W   = 31;
    localparam int PRE_W    = 33;
    localparam int INDEX_W  = 16;

    localparam logic [COORD_W-1:0] COORD_MAX  = 6'd49;
    localparam logic [COORD_W-1:0] GRID_MIN   = 6'd2;
    localparam logic [COORD_W-1:0] GRID_MAX   = 6'd50;
    localparam logic [COORD_W-1:0] GRID_RESET = 6'd2;

    // floor(p / 50) == (p * 1311) >> 16 for every p up to 49 * 52
    localparam int QUANT_RECIP = 1311;
    localparam int QUANT_SHIFT = 16;

    localparam int SEG_BASE = 53;

    // base = 3*2^27 + 5, modulus = 3*2^29 + 5
    localparam int BASE_SHIFT = 27;
    localparam logic [PRE_W-1:0] MOD_X1 = 33'd1610612741;
    localparam logic [PRE_W-1:0] MOD_X2 = 33'd3221225482;
    localparam logic [PRE_W-1:0] MOD_X3 = 33'd4831838223;
    localparam logic [PRE_W-1:0] MOD_X4 = 33'd6442450964;

    typedef struct packed {
        logic              eot;
        logic [SEG_W-1:0]  seg;
    } t_seg_item;

    typedef struct packed {
        logic capture;
        logic load;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic              vld;
        logic              last;
        logic [HASH_W-1:0] hash;
    } t_slot;

    function automatic logic [COORD_W-1:0] grid_clamp(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if (v < GRID_MIN) begin
            r = GRID_MIN;
        end else if (v > GRID_MAX) begin
            r = GRID_MAX;
        end
        return r;
    endfunction

    function automatic logic [PROD_W-1:0] coord_scale(input logic [COORD_W-1:0] c,
                                                      input logic [COORD_W-1:0] grid);
        logic [COORD_W-1:0] s;
        s = (c > COORD_MAX) ? COORD_MAX : c;
        return PROD_W'(s) * PROD_W'(grid);
    endfunction

    function automatic logic [COORD_W-1:0] cell_of(input logic [PROD_W-1:0] p);
        logic [SEG_W-1:0] m;
        m = SEG_W'(p) * SEG_W'(QUANT_RECIP);
        return m[QUANT_SHIFT +: COORD_W];
    endfunction

    function automatic logic [SEG_W-1:0] seg_code(input logic [COORD_W-1:0] px,
                                                  input logic [COORD_W-1:0] py,
                                                  input logic [COORD_W-1:0] cx,
                                                  input logic [COORD_W-1:0] cy);
        logic [SEG_W-1:0] acc;
        acc = SEG_W'(px) * SEG_W'(SEG_BASE) + SEG_W'(py);
        acc = acc * SEG_W'(SEG_BASE) + SEG_W'(cx);
        acc = acc * SEG_W'(SEG_BASE) + SEG_W'(cy);
        return acc;
    endfunction

    // prev*base + seg folded below 5*modulus, using 3*2^29 == -5 (mod m)
    function automatic logic [PRE_W-1:0] hash_pre(input logic [HASH_W-1:0] prev,
                                                  input logic [SEG_W-1:0]  seg);
        logic [PRE_W:0] five_x;
        logic [PRE_W:0] five_a;
        logic [PRE_W:0] b_term;
        logic [PRE_W:0] sum;
        five_x = (PRE_W+1)'(prev) + (PRE_W+1)'({prev, 2'b00});
        five_a = (PRE_W+1)'(prev[HASH_W-1:2]) + (PRE_W+1)'({prev[HASH_W-1:2], 2'b00});
        b_term = ((PRE_W+1)'(prev[1:0]) + (PRE_W+1)'({prev[1:0], 1'b0})) << BASE_SHIFT;
        sum    = five_x - five_a + b_term + (PRE_W+1)'(seg);
        return sum[PRE_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] hash_reduce(input logic [PRE_W-1:0] t);
        logic [PRE_W-1:0] r;
        priority if (t >= MOD_X4) begin
            r = t - MOD_X4;
        end else if (t >= MOD_X3) begin
            r = t - MOD_X3;
        end else if (t >= MOD_X2) begin
            r = t - MOD_X2;
        end else if (t >= MOD_X1) begin
            r = t - MOD_X1;
        end else begin
            r = t;
        end
        return r[HASH_W-1:0];
    endfunction

endpackage

// ----- rtl/snrh_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrh_front
// Input pipeline: saturate and scale coordinates, quantise to grid cells,
// pair with the previous cell into a segment code.
// ----------------------------------------------------------------------------
module snrh_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [snrh_pkg::COORD_W-1:0]  i_grid,
    input  logic                          i_valid,
    input  logic [snrh_pkg::COORD_W-1:0]  i_coord_x,
    input  logic [snrh_pkg::COORD_W-1:0]  i_coord_y,
    input  logic                          i_end_of_track,
    output logic                          o_stall,
    input  logic                          i_ready,
    output logic                          o_vld,
    output snrh_pkg::t_seg_item           o_item
);

    logic                          r_s1_vld, r_s2_vld, r_s3_vld;
    logic                          r_s1_eot, r_s2_eot, r_s3_eot;
    logic [snrh_pkg::PROD_W-1:0]   r_s1_px, r_s1_py;
    logic [snrh_pkg::COORD_W-1:0]  r_s2_cx, r_s2_cy;
    logic [snrh_pkg::SEG_W-1:0]    r_s3_seg;
    logic [snrh_pkg::COORD_W-1:0]  r_prev_x, r_prev_y;
    logic                          r_have_prev;

    logic n_s1_vld, n_s2_vld, n_s3_vld;
    logic in_go, s1_go, s2_go, s3_go;
    logic s1_rdy, s2_rdy, s3_rdy;

    always_comb begin
        s3_go  = r_s3_vld & i_ready;
        s3_rdy = ~r_s3_vld | s3_go;
        s2_go  = r_s2_vld & s3_rdy;
        s2_rdy = ~r_s2_vld | s2_go;
        s1_go  = r_s1_vld & s2_rdy;
        s1_rdy = ~r_s1_vld | s1_go;
        in_go  = i_valid & s1_rdy;
    end

    always_comb begin
        n_s1_vld = in_go | (r_s1_vld & ~s1_go);
        n_s2_vld = s1_go | (r_s2_vld & ~s2_go);
        if (s2_go) begin
            n_s3_vld = r_s2_eot | r_have_prev;
        end else begin
            n_s3_vld = r_s3_vld & ~s3_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else begin
            r_s1_vld <= n_s1_vld;
            r_s2_vld <= n_s2_vld;
            r_s3_vld <= n_s3_vld;
            if (s2_go) begin
                if (r_s2_eot) begin
                    r_have_prev <= 1'b0;
                    r_prev_x    <= '0;
                    r_prev_y    <= '0;
                end else begin
                    r_have_prev <= 1'b1;
                    r_prev_x    <= r_s2_cx;
                    r_prev_y    <= r_s2_cy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_eot <= i_end_of_track;
            r_s1_px  <= snrh_pkg::coord_scale(i_coord_x, i_grid);
            r_s1_py  <= snrh_pkg::coord_scale(i_coord_y, i_grid);
        end
        if (s1_go) begin
            r_s2_eot <= r_s1_eot;
            r_s2_cx  <= snrh_pkg::cell_of(r_s1_px);
            r_s2_cy  <= snrh_pkg::cell_of(r_s1_py);
        end
        if (s2_go) begin
            r_s3_eot <= r_s2_eot;
            r_s3_seg <= snrh_pkg::seg_code(r_prev_x, r_prev_y, r_s2_cx, r_s2_cy);
        end
    end

    assign o_stall    = ~s1_rdy;
    assign o_vld      = r_s3_vld;
    assign o_item.eot = r_s3_eot;
    assign o_item.seg = r_s3_seg;

endmodule

// ----- rtl/snrh_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snrh_cell
// One window cell: holds the hash of the window ending at the previous
// segment, extends it by the new segment, and holds one result slot that
// shifts toward the output end of the chain.
// ----------------------------------------------------------------------------
module snrh_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  snrh_pkg::t_cell_ctl          i_ctl,
    input  logic                         i_take,
    input  logic                         i_last,
    input  logic [snrh_pkg::HASH_W-1:0]  i_prev_end,
    input  logic [snrh_pkg::SEG_W-1:0]   i_seg,
    input  snrh_pkg::t_slot              i_next,
    output logic [snrh_pkg::HASH_W-1:0]  o_end,
    output snrh_pkg::t_slot              o_slot
);

    logic [snrh_pkg::PRE_W-1:0]   r_t;
    logic [snrh_pkg::HASH_W-1:0]  r_end;
    logic                         r_vld;
    logic                         r_last;
    logic [snrh_pkg::HASH_W-1:0]  r_hash;
    logic [snrh_pkg::HASH_W-1:0]  fresh;

    assign fresh = snrh_pkg::hash_reduce(r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.load) begin
            r_vld <= i_take;
        end else if (i_ctl.shift) begin
            r_vld <= i_next.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_t <= snrh_pkg::hash_pre(i_prev_end, i_seg);
        end
        if (i_ctl.load) begin
            r_last <= i_last;
            r_hash <= fresh;
        end else if (i_ctl.shift) begin
            r_last <= i_next.last;
            r_hash <= i_next.hash;
        end
    end

    // window store starts at zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end <= '0;
        end else if (i_ctl.load && i_take) begin
            r_end <= fresh;
        end
    end

    assign o_end       = r_end;
    assign o_slot.vld  = r_vld;
    assign o_slot.last = r_last;
    assign o_slot.hash = r_hash;

endmodule

// ----- rtl/segment_ngram_rolling_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ngram_rolling_hash
// Quantises pointer positions to grid cells, forms segment codes and emits
// the rolling hashes of the windows of 1..WINDOW_MAX segments ending at each
// new segment, shortest first.
//
//   channel   handshake              payload
//   input     i_valid / o_stall      i_coord_x, i_coord_y, i_end_of_track
//   output    o_valid / i_stall      o_window_hash, o_window_length,
//                                    o_finish_index, o_last_of_run
//   config    i_grid_size_we         i_grid_size
//
// Points pass front stages s1 to s3, then s4 (hash pre-sum), then the cells.
// A point's windows (at most WINDOW_MAX) hold the result chain until the
// last is taken; the hash stage holds one item at a time. Track markers
// and first points of a track give no results.
// Synchronous reset clears all control and window state; no clearing pass.
// A stall on the output backs up through the chain into o_stall.
// ----------------------------------------------------------------------------
module segment_ngram_rolling_hash #(
    parameter int WINDOW_MAX = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_grid_size_we,
    input  logic [snrh_pkg::COORD_W-1:0]           i_grid_size,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [snrh_pkg::COORD_W-1:0]           i_coord_x,
    input  logic [snrh_pkg::COORD_W-1:0]           i_coord_y,
    input  logic                                   i_end_of_track,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [snrh_pkg::HASH_W-1:0]            o_window_hash,
    output logic [$clog2(WINDOW_MAX+1)-1:0]        o_window_length,
    output logic [snrh_pkg::INDEX_W-1:0]           o_finish_index,
    output logic                                   o_last_of_run
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int HV_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [snrh_pkg::COORD_W-1:0]  r_grid;
    logic                          r_s4_vld;
    logic                          r_s4_eot;
    logic [HV_W-1:0]               r_hv;
    logic [LEN_W-1:0]              r_pop;
    logic [snrh_pkg::INDEX_W-1:0]  r_seg_cnt;
    logic [snrh_pkg::INDEX_W-1:0]  r_out_index;

    logic                          front_vld;
    snrh_pkg::t_seg_item           front_item;
    snrh_pkg::t_cell_ctl           ctl;

    logic [snrh_pkg::HASH_W-1:0]   w_end  [0:WINDOW_MAX];
    snrh_pkg::t_slot               w_slot [0:WINDOW_MAX];

    logic s3_go, s4_go, pop, chain_free, load;

    snrh_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grid         (r_grid),
        .i_valid        (i_valid),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_end_of_track (i_end_of_track),
        .o_stall        (o_stall),
        .i_ready        (~r_s4_vld),
        .o_vld          (front_vld),
        .o_item         (front_item)
    );

    always_comb begin
        pop        = w_slot[0].vld & ~i_stall;
        chain_free = ~w_slot[0].vld | (pop & w_slot[0].last);
        s3_go      = front_vld & ~r_s4_vld;
        s4_go      = r_s4_vld & (r_s4_eot | chain_free);
        load       = s4_go & ~r_s4_eot;
        ctl.capture = s3_go;
        ctl.load    = load;
        ctl.shift   = pop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid    <= snrh_pkg::GRID_RESET;
            r_s4_vld  <= 1'b0;
            r_hv      <= '0;
            r_pop     <= '0;
            r_seg_cnt <= '0;
        end else begin
            if (i_grid_size_we) begin
                r_grid <= snrh_pkg::grid_clamp(i_grid_size);
            end
            r_s4_vld <= s3_go | (r_s4_vld & ~s4_go);
            if (load) begin
                r_pop     <= '0;
                r_seg_cnt <= r_seg_cnt + 1'b1;
                if (r_hv != HV_W'(WINDOW_MAX - 1)) begin
                    r_hv <= r_hv + 1'b1;
                end
            end else begin
                if (s4_go) begin
                    r_seg_cnt <= '0;
                    r_hv      <= '0;
                end
                if (pop) begin
                    r_pop <= r_pop + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_go) begin
            r_s4_eot <= front_item.eot;
        end
        if (load) begin
            r_out_index <= r_seg_cnt;
        end
    end

    assign w_end[0]           = '0;
    assign w_slot[WINDOW_MAX] = '0;

    for (genvar gk = 0; gk < WINDOW_MAX; gk++) begin : g_cell
        snrh_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_take     (HV_W'(gk) <= r_hv),
            .i_last     (HV_W'(gk) == r_hv),
            .i_prev_end (w_end[gk]),
            .i_seg      (front_item.seg),
            .i_next     (w_slot[gk+1]),
            .o_end      (w_end[gk+1]),
            .o_slot     (w_slot[gk])
        );
    end

    assign o_valid         = w_slot[0].vld;
    assign o_window_hash   = w_slot[0].hash;
    assign o_last_of_run   = w_slot[0].last;
    assign o_window_length = r_pop + 1'b1;
    assign o_finish_index  = r_out_index;

endmodule

// ----- tb/sv/segment_ngram_rolling_hash_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ngram_rolling_hash_tb
// Self-checking bench for the segment n-gram rolling hash. Pointer tracks are
// sent through the input channel, a cycle-free predictor builds the expected
// window hashes, and every output transaction is checked in order. Covers
// corner coordinates, grid clamping, random tracks under random idling and a
// long output hold.
// ----------------------------------------------------------------------------
module segment_ngram_rolling_hash_tb;

    localparam int WIN_MAX = 6;
    localparam int LEN_W = $clog2(WIN_MAX + 1);
    localparam longint unsigned HASH_MULT = 64'd402653189;
    localparam longint unsigned HASH_PRIME = 64'd1610612741;
    localparam int unsigned SEG_RADIX = 53;
    localparam int unsigned SCREEN_SPAN = 50;
    localparam int unsigned COORD_TOP = 49;
    localparam int DRAIN_CYCLES = 24;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [snrh_pkg::HASH_W-1:0]  hash;
        logic [LEN_W-1:0]             length;
        logic [snrh_pkg::INDEX_W-1:0] index;
        logic                         last;
    } t_window_result;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [snrh_pkg::COORD_W-1:0] cfg_grid = '0;
    logic in_valid = 1'b0;
    logic out_stall;
    logic [snrh_pkg::COORD_W-1:0] in_x = '0;
    logic [snrh_pkg::COORD_W-1:0] in_y = '0;
    logic in_eot = 1'b0;
    logic out_valid;
    logic rx_stall;
    logic [snrh_pkg::HASH_W-1:0] out_hash;
    logic [LEN_W-1:0] out_len;
    logic [snrh_pkg::INDEX_W-1:0] out_idx;
    logic out_last;

    logic rx_wait = 1'b0;
    logic rx_hold = 1'b0;
    int unsigned rx_wait_left = 0;
    int unsigned hold_len = 0;
    event hold_go;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    assign rx_stall = rx_wait | rx_hold;

    // predictor state
    int unsigned grid_cells;
    int unsigned trk_prev_x;
    int unsigned trk_prev_y;
    bit trk_started;
    longint unsigned tail_hash [WIN_MAX-1];
    int unsigned tail_count;
    logic [snrh_pkg::INDEX_W-1:0] seg_index;

    t_window_result pending_windows [$];

    int errors = 0;
    int points_sent = 0;
    int markers_sent = 0;
    int results_checked = 0;
    int grid_writes = 0;
    longint sim_cycles = 0;

    segment_ngram_rolling_hash #(
        .WINDOW_MAX(WIN_MAX)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_grid_size_we  (cfg_we),
        .i_grid_size     (cfg_grid),
        .i_valid         (in_valid),
        .o_stall         (out_stall),
        .i_coord_x       (in_x),
        .i_coord_y       (in_y),
        .i_end_of_track  (in_eot),
        .o_valid         (out_valid),
        .i_stall         (rx_stall),
        .o_window_hash   (out_hash),
        .o_window_length (out_len),
        .o_finish_index  (out_idx),
        .o_last_of_run   (out_last)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (sim_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            sim_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic void clear_track_state();
        trk_prev_x = 0;
        trk_prev_y = 0;
        trk_started = 1'b0;
        foreach (tail_hash[i]) tail_hash[i] = 0;
        tail_count = 0;
        seg_index = '0;
    endfunction

    function automatic int unsigned quantize_coord(logic [snrh_pkg::COORD_W-1:0] c);
        int unsigned s;
        s = (c > COORD_TOP) ? COORD_TOP : 32'(c);
        return (s * grid_cells) / SCREEN_SPAN;
    endfunction

    // expected windows for one accepted transaction, shortest first
    function automatic void predict_point(logic [snrh_pkg::COORD_W-1:0] x,
                                          logic [snrh_pkg::COORD_W-1:0] y,
                                          logic eot);
        int unsigned cx, cy, n;
        longint unsigned seg, prev_h;
        longint unsigned fresh [WIN_MAX];
        t_window_result r;
        if (eot) begin
            clear_track_state();
            return;
        end
        cx = quantize_coord(x);
        cy = quantize_coord(y);
        if (!trk_started) begin
            trk_prev_x = cx;
            trk_prev_y = cy;
            trk_started = 1'b1;
            return;
        end
        seg = ((longint'(trk_prev_x) * SEG_RADIX + trk_prev_y) * SEG_RADIX + cx)
              * SEG_RADIX + cy;
        seg = seg % HASH_PRIME;
        n = (tail_count + 1 > WIN_MAX) ? WIN_MAX : tail_count + 1;
        for (int k = 0; k < n; k++) begin
            prev_h = (k == 0) ? 0 : tail_hash[k-1];
            fresh[k] = (prev_h * HASH_MULT + seg) % HASH_PRIME;
            r.hash = snrh_pkg::HASH_W'(fresh[k]);
            r.length = LEN_W'(k + 1);
            r.index = seg_index;
            r.last = (k + 1 == n);
            pending_windows = {pending_windows, r};
        end
        for (int k = 0; k < n && k < WIN_MAX - 1; k++) tail_hash[k] = fresh[k];
        tail_count = (n < WIN_MAX - 1) ? n : WIN_MAX - 1;
        seg_index = seg_index + 1'b1;
        trk_prev_x = cx;
        trk_prev_y = cy;
    endfunction

    function automatic logic [snrh_pkg::COORD_W-1:0] rand_coord();
        return ($urandom_range(0, 7) == 0) ? snrh_pkg::COORD_W'($urandom_range(50, 63))
                                           : snrh_pkg::COORD_W'($urandom_range(0, 49));
    endfunction

    function automatic logic [snrh_pkg::COORD_W-1:0] rand_any();
        return snrh_pkg::COORD_W'($urandom_range(0, 63));
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_window_result want;
        if (rst_n && out_valid && !rx_stall) begin
            if (pending_windows.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual hash %0d len %0d",
                         $time, out_hash, out_len);
            end else begin
                want = pending_windows.pop_front();
                results_checked++;
                check_field("window_hash", 64'(want.hash), 64'(out_hash));
                check_field("window_length", 64'(want.length), 64'(out_len));
                check_field("finish_index", 64'(want.index), 64'(out_idx));
                check_field("last_of_run", 64'(want.last), 64'(out_last));
            end
            rx_wait_left = rx_idle_en ? $urandom_range(0, 13) : 0;
        end
    end

    always @(negedge clk) begin
        if (rx_wait_left > 0) begin
            rx_wait = 1'b1;
            rx_wait_left--;
        end else begin
            rx_wait = 1'b0;
        end
    end

    // long output hold, counted here while the sender keeps going
    initial begin
        forever begin
            @(hold_go);
            rx_hold = 1'b1;
            repeat (hold_len) @(negedge clk);
            rx_hold = 1'b0;
        end
    end

    task automatic send_point(input logic [snrh_pkg::COORD_W-1:0] x,
                              input logic [snrh_pkg::COORD_W-1:0] y,
                              input logic eot);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, 13) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_x = x;
        in_y = y;
        in_eot = eot;
        while (out_stall) @(negedge clk);
        @(posedge clk);
        predict_point(x, y, eot);
        if (eot) markers_sent++;
        else points_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_windows.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_grid(input logic [snrh_pkg::COORD_W-1:0] value);
        wait_drained();
        cfg_we = 1'b1;
        cfg_grid = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (value < snrh_pkg::GRID_MIN) grid_cells = 32'(snrh_pkg::GRID_MIN);
        else if (value > snrh_pkg::GRID_MAX) grid_cells = 32'(snrh_pkg::GRID_MAX);
        else grid_cells = 32'(value);
        grid_writes++;
    endtask

    task automatic test_corner_points();
        send_point(6'd0, 6'd0, 1'b0);
        send_point(6'd49, 6'd49, 1'b0);
        send_point(6'd63, 6'd50, 1'b0);
        send_point(6'd50, 6'd0, 1'b0);
        send_point(6'd0, 6'd63, 1'b0);
        send_point(6'd32, 6'd17, 1'b0);
        send_point(6'd48, 6'd1, 1'b0);
        send_point(6'd63, 6'd63, 1'b1);
        send_point(6'd21, 6'd42, 1'b1);
        send_point(6'd5, 6'd45, 1'b0);
        send_point(6'd45, 6'd5, 1'b0);
        send_point(6'd7, 6'd7, 1'b1);
    endtask

    task automatic test_grid_clamp();
        logic [snrh_pkg::COORD_W-1:0] grids [4] = '{6'd0, 6'd63, 6'd1, 6'd51};
        foreach (grids[i]) begin
            write_grid(grids[i]);
            send_point(6'd49, 6'd0, 1'b0);
            send_point(6'd0, 6'd49, 1'b0);
            send_point(6'd0, 6'd0, 1'b1);
        end
    endtask

    task automatic test_random_tracks();
        int sent;
        int unsigned track_len;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_grid(6'd50);
                1: write_grid(6'd2);
                default: write_grid(rand_any());
            endcase
            tx_idle_en = (phase != 2);
            rx_idle_en = (phase != 3);
            sent = 0;
            while (sent < 32) begin
                track_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                         : $urandom_range(3, 14);
                repeat (track_len) begin
                    if ($urandom_range(0, 24) == 0) begin
                        send_point(rand_any(), rand_any(), 1'b1);
                        sent++;
                    end
                    send_point(rand_coord(), rand_coord(), 1'b0);
                    sent++;
                end
                send_point(rand_any(), rand_any(), 1'b1);
                sent++;
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        wait_drained();
        tx_idle_en = 1'b0;
        hold_len = 400;
        -> hold_go;
        repeat (40) send_point(rand_coord(), rand_coord(), 1'b0);
        send_point(6'd0, 6'd0, 1'b1);
        tx_idle_en = 1'b1;
        wait_drained();
    endtask

    initial begin
        grid_cells = 32'(snrh_pkg::GRID_RESET);
        clear_track_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_corner_points();
        test_grid_clamp();
        test_random_tracks();
        test_backpressure();
        wait_drained();

        $display("Sent %0d points and %0d end-of-track markers across %0d grid writes.",
                 points_sent, markers_sent, grid_writes);
        $display("Checked %0d window transactions, incl. a long output hold.",
                 results_checked);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
